// ===== rtl/srgm_pkg.sv =====
// Package with the types, constants and sequencer states of the slew-rate gain modifier.
package srgm_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 32;
    localparam int DT_W       = 20;
    localparam int NOW_W      = 32;
    localparam int MAX_W      = 31;
    localparam int TAU_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int RATE_W     = 31;
    localparam int CFG_DATA_W = 32;

    // Exceedance ring.
    localparam int NUM_EVENTS = 2;
    localparam int EV_IDX_W   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

    // Arithmetic constants.
    localparam logic [31:0] WIN_MS       = 32'd300;
    localparam logic [31:0] AGE_WIN_MS   = 32'((NUM_EVENTS + 1) * 300);
    localparam logic [28:0] RC_US_Q8     = 29'd1629747;
    localparam logic [30:0] ONE_Q30      = 31'd1073741824;
    localparam logic [31:0] EXP_M1_Q30   = 32'd395007542;
    localparam logic [30:0] SAT_RATE     = 31'h7FFF_FFFF;
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
    localparam logic [31:0] USEC_PER_MS  = 32'd1000;
    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [15:0] GAIN_ONE     = 16'd32768;
    localparam logic [23:0] TAU_RESET    = 24'd1000000;
    localparam int          TAYLOR_TERMS = 12;
    localparam int          K_W          = 4;
    localparam int          EXP_N_LIMIT  = 32;
    localparam int          N_W          = 5;

    // Shared divider geometry and quotient lengths of each division.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 35;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] NB_RATE  = 7'd53;
    localparam logic [DIV_CNT_W-1:0] NB_ALPHA = 7'd44;
    localparam logic [DIV_CNT_W-1:0] NB_DECAY = 7'd40;
    localparam logic [DIV_CNT_W-1:0] NB_EXPN  = 7'd42;
    localparam logic [DIV_CNT_W-1:0] NB_EXPF  = 7'd54;
    localparam logic [DIV_CNT_W-1:0] NB_TERM  = 7'd31;
    localparam logic [DIV_CNT_W-1:0] NB_GAIN  = 7'd47;

    typedef enum logic [0:0] {
        CFG_SLEW_MAX = 1'b0,
        CFG_TAU      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [5:0] {
        S_IDLE, S_DIFF, S_RATE_MUL, S_RATE_DIV, S_RATE_END,
        S_FDIFF, S_ALPHA_DIV, S_ALPHA_END, S_FMUL, S_FUPD,
        S_DECAY_DIV, S_DECAY_END,
        S_PPOS, S_PPOS_DEC, S_PPOS_WR, S_PNEG, S_PNEG_DEC, S_PNEG_WR,
        S_RAW, S_BLEND1, S_BLEND2, S_BLEND3,
        S_EVENTS, S_AGE, S_EXP_MUL, S_EXPN_DIV, S_EXPN_END,
        S_EXPF_DIV, S_EXPF_END, S_TMUL, S_TDIV, S_TEND, S_TCLAMP,
        S_EMUL, S_EWR, S_LIMMUL, S_LIMWR, S_GAIN, S_GAIN_END,
        S_DIV_WAIT, S_DONE
    } t_state;

endpackage

// ===== rtl/srgm_if.sv =====
// Channel interfaces of the slew-rate gain modifier: input, result and configuration.
interface srgm_in_if import srgm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [DT_W-1:0]            dt_us;
    logic [NOW_W-1:0]           now_ms;

    modport source (output valid, output sample, output dt_us, output now_ms, input ready);
    modport sink   (input valid, input sample, input dt_us, input now_ms, output ready);
endinterface

interface srgm_out_if import srgm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain_modifier;
    logic [RATE_W-1:0] smoothed_slew_rate;

    modport source (output valid, output gain_modifier, output smoothed_slew_rate, input ready);
    modport sink   (input valid, input gain_modifier, input smoothed_slew_rate, output ready);
endinterface

interface srgm_cfg_if import srgm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/slew_rate_gain_modifier.sv =====
// Top level of the slew-rate gain modifier: sequencer, shared multiplier and state.
//
// Usage: one request on i_in carries a Q16.16 sample, the time step in
// microseconds and a millisecond timestamp. Each request yields exactly one
// result on o_res: a Q1.15 gain modifier and the smoothed slew rate.
// Registers are written over i_cfg (index 0 threshold, index 1 time constant);
// the configuration channel is always ready and should only be used while the
// block has no request in flight.
// A request with a zero time step goes from idle straight to the final state.
// Any other request walks a sequencer that reuses one registered multiplier
// and one restoring divider producing one quotient bit per cycle. The
// divisions dominate the run time, most of all with exceedance attenuation
// (twelve Taylor divisions plus up to 31 exp(-1) multiplications).
// i_in.ready is high only while the sequencer is idle, so one request is in
// work at a time. The result sits in an output register; the next request is
// accepted while it waits, and a finished result only stalls in the final
// state until the receiver takes the previous one.
// Reset is synchronous and active low: all filter, peak and event state goes
// to zero, the threshold to zero and the time constant to one second.
module slew_rate_gain_modifier import srgm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srgm_in_if.sink     i_in,
    srgm_out_if.source  o_res,
    srgm_cfg_if.sink    i_cfg
);

    // Configuration.
    logic [MAX_W-1:0] r_max;
    logic [TAU_W-1:0] r_tau;

    // Architectural state.
    logic signed [31:0] r_prev;
    logic signed [31:0] r_filt;
    logic [31:0]        r_pos;
    logic [31:0]        r_neg;
    logic [31:0]        r_ptime;
    logic [31:0]        r_ntime;
    logic [31:0]        r_ptimes [NUM_EVENTS];
    logic [31:0]        r_ntimes [NUM_EVENTS];
    logic [EV_IDX_W-1:0] r_pslot;
    logic [EV_IDX_W-1:0] r_nslot;
    logic               r_platch;
    logic               r_nlatch;
    logic [31:0]        r_orate;
    logic [31:0]        r_mrate;

    // Sequencer and working registers.
    t_state             r_state;
    t_state             n_state;
    t_state             r_ret;
    logic signed [SAMPLE_W-1:0] r_s;
    logic [DT_W-1:0]    r_dt;
    logic [NOW_W-1:0]   r_now;
    logic               r_sgn;
    logic [32:0]        r_mag;
    logic signed [31:0] r_rate;
    logic [16:0]        r_alpha;
    logic [16:0]        r_decay;
    logic [16:0]        r_attack;
    logic [31:0]        r_bin;
    logic               r_bmod;
    logic [48:0]        r_acc;
    logic [31:0]        r_lim;
    logic [31:0]        r_age;
    logic [N_W-1:0]     r_n;
    logic [29:0]        r_frac;
    logic [30:0]        r_term;
    logic signed [32:0] r_sum;
    logic [K_W-1:0]     r_k;
    logic [30:0]        r_v;
    logic [GAIN_W-1:0]  r_gain;
    logic [64:0]        r_prod;

    // Result register.
    logic              r_out_valid;
    logic [GAIN_W-1:0] r_out_gain;
    logic [RATE_W-1:0] r_out_rate;

    // Shared units.
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    // Combinational helpers.
    logic               in_fire;
    logic               out_free;
    logic [TAU_W-1:0]   tau_eff;
    logic [TAU_W-1:0]   dt_lim;
    logic signed [32:0] d_in;
    logic signed [32:0] d_filt;
    logic signed [33:0] slew_ext;
    logic signed [33:0] nslew_ext;
    logic               pos_new;
    logic               neg_new;
    logic [34:0]        cap;
    logic [31:0]        pp;
    logic [31:0]        pn;
    logic [32:0]        lim_sum;
    logic               p_fire;
    logic               n_fire;
    logic               nl_mid;
    logic [31:0]        oldest;
    logic [31:0]        age;
    logic [30:0]        sat_mag;
    logic [32:0]        fstep;
    logic [49:0]        bsum;
    logic [33:0]        bval;
    logic [31:0]        bres;
    logic [33:0]        gain_den;
    logic [30:0]        tclamp;
    logic [31:0]        blend_old;

    srgm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign mul_p    = mul_a * mul_b;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign tau_eff  = (r_tau == '0) ? TAU_W'(1) : r_tau;
    assign dt_lim   = ({4'b0, r_dt} < tau_eff) ? {4'b0, r_dt} : tau_eff;
    assign d_in     = {r_s[31], r_s} - {r_prev[31], r_prev};
    assign d_filt   = {r_rate[31], r_rate} - {r_filt[31], r_filt};
    assign slew_ext = {{2{r_filt[31]}}, r_filt};
    assign nslew_ext = -slew_ext;
    assign pos_new  = slew_ext > $signed({2'b0, r_pos});
    assign neg_new  = nslew_ext > $signed({2'b0, r_neg});

    // The peak cap is ten times the threshold, built from two shifts.
    assign cap     = ({4'b0, r_max} << 3) + ({4'b0, r_max} << 1);
    assign pp      = ({3'b0, r_pos} < cap) ? r_pos : cap[31:0];
    assign pn      = ({3'b0, r_neg} < cap) ? r_neg : cap[31:0];
    assign lim_sum = {1'b0, pp} + {1'b0, pn};

    // A positive exceedance re-arms the negative latch before it is checked.
    assign p_fire = !r_platch && (slew_ext > $signed({3'b0, r_max}));
    assign nl_mid = p_fire ? 1'b0 : r_nlatch;
    assign n_fire = !nl_mid && (nslew_ext > $signed({3'b0, r_max}));

    always_comb begin
        oldest = r_now;
        for (int i = 0; i < NUM_EVENTS; i++) begin
            if (r_ptimes[i] < oldest) oldest = r_ptimes[i];
            if (r_ntimes[i] < oldest) oldest = r_ntimes[i];
        end
    end
    assign age = r_now - oldest;

    assign sat_mag  = (div_rsp.quo > {33'b0, SAT_RATE}) ? SAT_RATE : div_rsp.quo[30:0];
    assign fstep    = r_prod[48:16];
    assign bsum     = {1'b0, r_acc} + {1'b0, r_prod[48:0]};
    assign bval     = bsum[49:16];
    assign bres     = (bval > {2'b0, r_bin}) ? r_bin : bval[31:0];
    assign gain_den = {2'b0, r_mrate} + {1'b0, r_mrate, 1'b0} - {3'b0, r_max};
    assign tclamp   = r_sum[32] ? '0 :
                      (r_sum > $signed({2'b0, ONE_Q30})) ? ONE_Q30 : r_sum[30:0];
    assign blend_old = r_bmod ? r_mrate : r_orate;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (in_fire) n_state = (i_in.dt_us == '0) ? S_DONE : S_DIFF;
            S_DIFF:      n_state = S_RATE_MUL;
            S_RATE_MUL:  n_state = S_RATE_DIV;
            S_RATE_DIV:  n_state = S_DIV_WAIT;
            S_RATE_END:  n_state = S_FDIFF;
            S_FDIFF:     n_state = S_ALPHA_DIV;
            S_ALPHA_DIV: n_state = S_DIV_WAIT;
            S_ALPHA_END: n_state = S_FMUL;
            S_FMUL:      n_state = S_FUPD;
            S_FUPD:      n_state = S_DECAY_DIV;
            S_DECAY_DIV: n_state = S_DIV_WAIT;
            S_DECAY_END: n_state = S_PPOS;
            S_PPOS: begin
                if (pos_new) n_state = S_PNEG;
                else if ((r_now - r_ptime) > WIN_MS) n_state = S_PPOS_DEC;
                else n_state = S_PNEG;
            end
            S_PPOS_DEC:  n_state = S_PPOS_WR;
            S_PPOS_WR:   n_state = S_PNEG;
            S_PNEG: begin
                if (neg_new) n_state = S_RAW;
                else if ((r_now - r_ntime) > WIN_MS) n_state = S_PNEG_DEC;
                else n_state = S_RAW;
            end
            S_PNEG_DEC:  n_state = S_PNEG_WR;
            S_PNEG_WR:   n_state = S_RAW;
            S_RAW:       n_state = S_BLEND1;
            S_BLEND1:    n_state = S_BLEND2;
            S_BLEND2:    n_state = S_BLEND3;
            S_BLEND3: begin
                if (r_bmod) n_state = S_GAIN;
                else if (r_max == '0) n_state = S_DONE;
                else n_state = S_EVENTS;
            end
            S_EVENTS:    n_state = S_AGE;
            S_AGE:       n_state = (age > AGE_WIN_MS) ? S_EXP_MUL : S_BLEND1;
            S_EXP_MUL:   n_state = S_EXPN_DIV;
            S_EXPN_DIV:  n_state = S_DIV_WAIT;
            S_EXPN_END:  n_state = (div_rsp.quo >= 64'(EXP_N_LIMIT)) ? S_LIMMUL : S_EXPF_DIV;
            S_EXPF_DIV:  n_state = S_DIV_WAIT;
            S_EXPF_END:  n_state = S_TMUL;
            S_TMUL:      n_state = S_TDIV;
            S_TDIV:      n_state = S_DIV_WAIT;
            S_TEND:      n_state = (r_k == K_W'(TAYLOR_TERMS)) ? S_TCLAMP : S_TMUL;
            S_TCLAMP:    n_state = (r_n == '0) ? S_LIMMUL : S_EMUL;
            S_EMUL:      n_state = S_EWR;
            S_EWR:       n_state = (r_n == N_W'(1)) ? S_LIMMUL : S_EMUL;
            S_LIMMUL:    n_state = S_LIMWR;
            S_LIMWR:     n_state = S_BLEND1;
            S_GAIN:      n_state = (r_mrate > {1'b0, r_max}) ? S_DIV_WAIT : S_DONE;
            S_GAIN_END:  n_state = S_DONE;
            S_DIV_WAIT:  if (div_rsp.done) n_state = r_ret;
            S_DONE:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, divider request, multiplier operands.
    always_comb begin
        i_in.ready    = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        div_req.nbits = '0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_IDLE:      i_in.ready = 1'b1;
            S_RATE_MUL: begin
                mul_a = r_mag;
                mul_b = USEC_PER_SEC;
            end
            S_RATE_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {11'b0, r_prod[52:0]};
                div_req.den   = {15'b0, r_dt};
                div_req.nbits = NB_RATE;
            end
            S_ALPHA_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {20'b0, r_dt, 24'b0};
                div_req.den   = {6'b0, ({1'b0, r_dt, 8'b0} + RC_US_Q8)};
                div_req.nbits = NB_ALPHA;
            end
            S_FMUL: begin
                mul_a = r_mag;
                mul_b = {15'b0, r_alpha};
            end
            S_DECAY_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {24'b0, dt_lim, 16'b0};
                div_req.den   = {11'b0, tau_eff};
                div_req.nbits = NB_DECAY;
            end
            S_PPOS_DEC: begin
                mul_a = {1'b0, r_pos};
                mul_b = {15'b0, Q16_ONE - r_decay};
            end
            S_PNEG_DEC: begin
                mul_a = {1'b0, r_neg};
                mul_b = {15'b0, Q16_ONE - r_decay};
            end
            S_BLEND1: begin
                mul_a = {1'b0, blend_old};
                mul_b = {15'b0, Q16_ONE - r_attack};
            end
            S_BLEND2: begin
                mul_a = {1'b0, r_bin};
                mul_b = {15'b0, r_attack};
            end
            S_EXP_MUL: begin
                mul_a = {1'b0, r_age - AGE_WIN_MS};
                mul_b = USEC_PER_MS;
            end
            S_EXPN_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {22'b0, r_prod[41:0]};
                div_req.den   = {11'b0, tau_eff};
                div_req.nbits = NB_EXPN;
            end
            S_EXPF_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = {10'b0, div_rsp.rem[23:0], 30'b0};
                div_req.den   = {11'b0, tau_eff};
                div_req.nbits = NB_EXPF;
            end
            S_TMUL: begin
                mul_a = {2'b0, r_term};
                mul_b = {2'b0, r_frac};
            end
            S_TDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {33'b0, r_prod[60:30]};
                div_req.den   = {31'b0, r_k};
                div_req.nbits = NB_TERM;
            end
            S_EMUL: begin
                mul_a = {2'b0, r_v};
                mul_b = EXP_M1_Q30;
            end
            S_LIMMUL: begin
                mul_a = {1'b0, r_lim};
                mul_b = {1'b0, r_v};
            end
            S_GAIN: begin
                div_req.start = r_mrate > {1'b0, r_max};
                div_req.num   = {17'b0, r_max, 16'b0};
                div_req.den   = {1'b0, gain_den};
                div_req.nbits = NB_GAIN;
            end
            default: begin
            end
        endcase
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_tau <= TAU_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_SLEW_MAX: r_max <= i_cfg.data[MAX_W-1:0];
                CFG_TAU:      r_tau <= i_cfg.data[TAU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Shared multiplier product register.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    // Architectural state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_filt   <= '0;
            r_pos    <= '0;
            r_neg    <= '0;
            r_ptime  <= '0;
            r_ntime  <= '0;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                r_ptimes[i] <= '0;
                r_ntimes[i] <= '0;
            end
            r_pslot  <= '0;
            r_nslot  <= '0;
            r_platch <= 1'b0;
            r_nlatch <= 1'b0;
            r_orate  <= '0;
            r_mrate  <= '0;
        end else begin
            case (r_state)
                S_FUPD: begin
                    r_filt <= r_sgn ? 32'(r_filt - $signed(fstep))
                                    : 32'(r_filt + $signed(fstep));
                    r_prev <= r_s;
                end
                S_PPOS: begin
                    if (pos_new) begin
                        r_pos   <= r_filt;
                        r_ptime <= r_now;
                    end
                end
                S_PPOS_WR: r_pos <= r_prod[47:16];
                S_PNEG: begin
                    if (neg_new) begin
                        r_neg   <= nslew_ext[31:0];
                        r_ntime <= r_now;
                    end
                end
                S_PNEG_WR: r_neg <= r_prod[47:16];
                S_BLEND3: begin
                    if (r_bmod) r_mrate <= bres;
                    else r_orate <= bres;
                end
                S_EVENTS: begin
                    if (p_fire) begin
                        r_ptimes[r_pslot] <= r_now;
                        r_pslot  <= (r_pslot == EV_IDX_W'(NUM_EVENTS - 1)) ? '0
                                    : r_pslot + 1'b1;
                        r_platch <= 1'b1;
                        r_nlatch <= 1'b0;
                    end
                    if (n_fire) begin
                        r_ntimes[r_nslot] <= r_now;
                        r_nslot  <= (r_nslot == EV_IDX_W'(NUM_EVENTS - 1)) ? '0
                                    : r_nslot + 1'b1;
                        r_nlatch <= 1'b1;
                        r_platch <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_s    <= i_in.sample;
                    r_dt   <= i_in.dt_us;
                    r_now  <= i_in.now_ms;
                    r_gain <= GAIN_ONE;
                end
            end
            S_DIFF: begin
                r_sgn <= d_in[32];
                r_mag <= d_in[32] ? 33'(-d_in) : d_in;
            end
            S_RATE_DIV:  r_ret <= S_RATE_END;
            S_RATE_END:  r_rate <= r_sgn ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});
            S_FDIFF: begin
                r_sgn <= d_filt[32];
                r_mag <= d_filt[32] ? 33'(-d_filt) : d_filt;
            end
            S_ALPHA_DIV: r_ret <= S_ALPHA_END;
            S_ALPHA_END: r_alpha <= div_rsp.quo[16:0];
            S_DECAY_DIV: r_ret <= S_DECAY_END;
            S_DECAY_END: begin
                r_decay  <= div_rsp.quo[16:0];
                r_attack <= (div_rsp.quo[17:0] > 18'(Q16_ONE >> 1)) ? Q16_ONE
                            : {div_rsp.quo[15:0], 1'b0};
            end
            S_RAW: begin
                r_bin  <= 32'(({1'b0, r_pos} + {1'b0, r_neg}) >> 1);
                r_bmod <= 1'b0;
            end
            S_BLEND2: r_acc <= r_prod[48:0];
            S_EVENTS: r_lim <= lim_sum[32:1];
            S_AGE: begin
                r_age  <= age;
                r_bin  <= r_lim;
                r_bmod <= 1'b1;
            end
            S_EXPN_DIV:  r_ret <= S_EXPN_END;
            S_EXPN_END: begin
                r_n <= div_rsp.quo[N_W-1:0];
                r_v <= '0;
            end
            S_EXPF_DIV:  r_ret <= S_EXPF_END;
            S_EXPF_END: begin
                r_frac <= div_rsp.quo[29:0];
                r_term <= ONE_Q30;
                r_sum  <= $signed({2'b0, ONE_Q30});
                r_k    <= K_W'(1);
            end
            S_TDIV:      r_ret <= S_TEND;
            S_TEND: begin
                r_term <= div_rsp.quo[30:0];
                r_sum  <= r_k[0] ? r_sum - $signed({2'b0, div_rsp.quo[30:0]})
                                 : r_sum + $signed({2'b0, div_rsp.quo[30:0]});
                r_k    <= r_k + 1'b1;
            end
            S_TCLAMP:    r_v <= tclamp;
            S_EWR: begin
                r_v <= r_prod[60:30];
                r_n <= r_n - 1'b1;
            end
            S_LIMWR: begin
                r_bin  <= r_prod[61:30];
                r_bmod <= 1'b1;
            end
            S_GAIN:      r_ret <= S_GAIN_END;
            S_GAIN_END:  r_gain <= div_rsp.quo[GAIN_W-1:0];
            default: begin
            end
        endcase
    end

    // Result register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_gain <= r_gain;
            r_out_rate <= r_orate[RATE_W-1:0];
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.gain_modifier      = r_out_gain;
    assign o_res.smoothed_slew_rate = r_out_rate;

    // The divider is never restarted while it is still working.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // An accepted request always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state != S_IDLE)
        else $error("request accepted without starting work");

    // The exp(-1) loop only runs with iterations left.
    a_exp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMUL) |-> (r_n != '0))
        else $error("exp loop entered with zero count");

    // A delivered gain never exceeds unity.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.gain_modifier <= GAIN_ONE))
        else $error("gain modifier above one");

    // The result register is loaded only when its previous content is gone.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(r_out_gain))
        else $error("pending result overwritten");

endmodule

// ===== rtl/srgm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, shared by the sequencer.
module srgm_div import srgm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_r;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;
    logic [DIV_CNT_W-1:0] align;

    assign trial = {r_r, r_q[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};
    assign align = DIV_CNT_W'(DIV_NUM_W) - i_req.nbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The numerator is left aligned so that only its significant bits are walked.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num << align;
            r_r   <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_q <= {r_q[DIV_NUM_W-2:0], fits};
            r_r <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_r;

endmodule

// ===== dv/slew_rate_gain_modifier_tb.sv =====
// Self-checking testbench of the slew-rate gain modifier with a bit-exact predictor.
module slew_rate_gain_modifier_tb;
    import srgm_pkg::*;

    // A generous limit on the run. It covers the slowest requests, those with
    // exceedance attenuation, plus sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_PER_PHASE = 110;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [DT_W-1:0]            dt_us;
        logic [NOW_W-1:0]           now_ms;
    } t_request;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [RATE_W-1:0] rate;
    } t_gain_result;

    logic i_clk;
    logic i_rst_n;

    srgm_in_if  in_if ();
    srgm_out_if res_if ();
    srgm_cfg_if cfg_if ();

    slew_rate_gain_modifier dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    t_request     pending_requests[$];
    t_gain_result expected_gains[$];
    int           error_count;
    int           accepted_count;
    int           result_count;
    int           zero_step_count;
    int           phase_count;
    int unsigned  cycle_count;

    // Predictor copy of the block's registers and state.
    logic [30:0]        thr_max;
    logic [23:0]        tau_us;
    logic signed [31:0] prev_sample;
    logic signed [31:0] filt_rate;
    logic [31:0]        peak_pos, peak_neg, peak_pos_ms, peak_neg_ms;
    logic [31:0]        pos_ring[NUM_EVENTS];
    logic [31:0]        neg_ring[NUM_EVENTS];
    int unsigned        pos_slot, neg_slot;
    logic               pos_latched, neg_latched;
    logic [31:0]        out_rate, mod_rate;

    // Request generator state: a running timeline and signal level.
    logic [31:0] gen_now;
    logic [31:0] gen_sample;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // exp(-f) for a Q30 fraction through an alternating Taylor series.
    function automatic longint unsigned exp_fraction(input longint unsigned f);
        longint unsigned term;
        longint          sum;
        term = 64'd1073741824;
        sum  = 64'sd1073741824;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = ((term * f) >> 30) / k;
            if (k % 2 == 1) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        if (sum < 0) sum = 0;
        if (sum > 64'sd1073741824) sum = 64'sd1073741824;
        return longint'(sum);
    endfunction

    // exp(-excess*1000/tau) in Q30, zero once the integer part reaches 32.
    function automatic longint unsigned attenuation(input longint unsigned excess_ms,
                                                    input longint unsigned tau);
        longint unsigned num, whole, frac, v;
        num   = excess_ms * 1000;
        whole = num / tau;
        frac  = ((num % tau) << 30) / tau;
        if (whole >= 32) return 0;
        v = exp_fraction(frac);
        for (longint unsigned i = 0; i < whole; i++) v = (v * 64'd395007542) >> 30;
        return v;
    endfunction

    function automatic logic [31:0] smooth(input logic [31:0] old_v, input longint unsigned in_v,
                                           input longint unsigned a);
        longint unsigned v;
        v = ((64'd65536 - a) * old_v + a * in_v) >> 16;
        if (v > in_v) v = in_v;
        return v[31:0];
    endfunction

    function automatic logic [31:0] decayed(input logic [31:0] p, input longint unsigned d);
        longint unsigned v;
        v = (longint'(p) * (64'd65536 - d)) >> 16;
        return v[31:0];
    endfunction

    // Advances the predictor by one request and returns the result it causes.
    function automatic t_gain_result predict_gain(input t_request r);
        t_gain_result    res;
        longint          s, d, rate, slew;
        longint unsigned mag, alpha, m, tau, dt, decay, attack, cap, pp, pn, lim, mi;
        logic [31:0]     oldest, age;
        tau = (tau_us == 0) ? 1 : tau_us;
        dt  = r.dt_us;
        res.gain = GAIN_ONE;
        if (dt == 0) begin
            res.rate = out_rate[30:0];
            return res;
        end

        s    = longint'(r.sample);
        d    = s - longint'(prev_sample);
        mag  = (d < 0) ? -d : d;
        mag  = mag * 1000000 / dt;
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        rate = (d < 0) ? -longint'(mag) : longint'(mag);

        alpha = (dt << 24) / ((dt << 8) + 64'd1629747);
        d     = rate - longint'(filt_rate);
        m     = (d < 0) ? -d : d;
        m     = (m * alpha) >> 16;
        slew  = (d < 0) ? longint'(filt_rate) - longint'(m) : longint'(filt_rate) + longint'(m);
        filt_rate   = slew[31:0];
        prev_sample = r.sample;

        decay  = (((dt < tau) ? dt : tau) << 16) / tau;
        attack = (decay * 2 > 65536) ? 65536 : decay * 2;

        // Peaks are replaced when exceeded and decay only outside the window.
        if (slew > longint'(peak_pos)) begin
            peak_pos    = slew[31:0];
            peak_pos_ms = r.now_ms;
        end else if (r.now_ms - peak_pos_ms > WIN_MS) begin
            peak_pos = decayed(peak_pos, decay);
        end
        if (-slew > longint'(peak_neg)) begin
            peak_neg    = 32'(-slew);
            peak_neg_ms = r.now_ms;
        end else if (r.now_ms - peak_neg_ms > WIN_MS) begin
            peak_neg = decayed(peak_neg, decay);
        end

        out_rate = smooth(out_rate, (longint'(peak_pos) + longint'(peak_neg)) >> 1, attack);
        res.rate = out_rate[30:0];

        // A zero threshold leaves the exceedance rings and the modifier rate alone.
        if (thr_max != 0) begin
            cap = longint'(thr_max) * 10;
            pp  = (peak_pos < cap) ? peak_pos : cap;
            pn  = (peak_neg < cap) ? peak_neg : cap;
            lim = (pp + pn) >> 1;

            // Each direction records one exceedance until the other direction fires.
            if (!pos_latched && slew > longint'(thr_max)) begin
                if (pos_slot >= NUM_EVENTS) pos_slot = 0;
                pos_ring[pos_slot] = r.now_ms;
                pos_slot++;
                pos_latched = 1'b1;
                neg_latched = 1'b0;
            end
            if (!neg_latched && -slew > longint'(thr_max)) begin
                if (neg_slot >= NUM_EVENTS) neg_slot = 0;
                neg_ring[neg_slot] = r.now_ms;
                neg_slot++;
                neg_latched = 1'b1;
                pos_latched = 1'b0;
            end

            oldest = r.now_ms;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                if (pos_ring[i] < oldest) oldest = pos_ring[i];
                if (neg_ring[i] < oldest) oldest = neg_ring[i];
            end
            age = r.now_ms - oldest;
            mi  = lim;
            if (age > AGE_WIN_MS) mi = (lim * attenuation(age - AGE_WIN_MS, tau)) >> 30;
            mod_rate = smooth(mod_rate, mi, attack);

            if (mod_rate > thr_max) begin
                res.gain = 16'(((longint'(thr_max)) << 16) /
                               (longint'(mod_rate) * 3 - longint'(thr_max)));
            end
        end
        return res;
    endfunction

    // Driver: requests leave the queue in bursts with random gaps between them.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  <= 1;
            gap_left    <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_gains.push_back(predict_gain({in_if.sample, in_if.dt_us, in_if.now_ms}));
                accepted_count++;
                if (in_if.dt_us == 0) zero_step_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    t_request r;
                    r = pending_requests.pop_front();
                    in_if.sample <= r.sample;
                    in_if.dt_us  <= r.dt_us;
                    in_if.now_ms <= r.now_ms;
                    in_if.valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver stalls on a duty pattern that changes now and then,
    // including stretches where it never stalls.
    int stall_period, ready_slots, pattern_age, pattern_pos;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_period <= 1;
            ready_slots  <= 1;
            pattern_age  <= 0;
            pattern_pos  <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                t_gain_result want;
                result_count++;
                if (expected_gains.size() == 0) begin
                    report("unexpected result, gain", res_if.gain_modifier, 0);
                end else begin
                    want = expected_gains.pop_front();
                    if (res_if.gain_modifier !== want.gain)
                        report("gain_modifier", res_if.gain_modifier, want.gain);
                    if (res_if.smoothed_slew_rate !== want.rate)
                        report("smoothed_slew_rate", res_if.smoothed_slew_rate, want.rate);
                end
            end
            if (pattern_age >= 600) begin
                int p;
                p = $urandom_range(1, 9);
                stall_period <= p;
                ready_slots  <= ($urandom_range(0, 3) == 0) ? p : $urandom_range(1, p);
                pattern_age  <= 0;
                pattern_pos  <= 0;
            end else begin
                pattern_age <= pattern_age + 1;
                pattern_pos <= (pattern_pos + 1 >= stall_period) ? 0 : pattern_pos + 1;
            end
            res_if.ready <= (pattern_pos < ready_slots);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_gains.size());
            $display("slew_rate_gain_modifier verification failed");
            $finish;
        end
    end

    // Register writes happen only while the block is idle.
    task automatic write_register(input t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_SLEW_MAX) thr_max = value[30:0];
        else tau_us = value[23:0];
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_gains.size() != 0 || in_if.valid);
    endtask

    task automatic push_request(input logic [31:0] smp, input logic [19:0] dt, input logic [31:0] now);
        pending_requests.push_back({smp, dt, now});
    endtask

    // Mostly a plausible timeline with random content, some zero steps and some noise.
    task automatic push_random();
        int   r;
        logic [31:0] step;
        logic [19:0] dt;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            push_request($urandom, 20'd0, gen_now);
        end else if (r < 16) begin
            push_request($urandom, 20'($urandom_range(1, 1000000)), $urandom);
        end else begin
            dt = (r < 22) ? 20'($urandom_range(1, 1000000)) : 20'($urandom_range(200, 20000));
            gen_now += dt / 1000;
            if ($urandom_range(0, 5) == 0) gen_now += $urandom_range(0, 3000);
            step = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
            gen_sample += ($urandom_range(0, 1) == 0) ? step : -step;
            push_request(gen_sample, dt, gen_now);
        end
    endtask

    initial begin
        logic [31:0] phase_max[8];
        logic [31:0] phase_tau[8];

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        in_if.dt_us  = '0;
        in_if.now_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_SLEW_MAX;
        cfg_if.data  = '0;
        res_if.ready = 1'b0;
        cycle_count  = 0;
        error_count  = 0;

        thr_max     = '0;
        tau_us      = TAU_RESET;
        prev_sample = '0;
        filt_rate   = '0;
        peak_pos    = '0;
        peak_neg    = '0;
        peak_pos_ms = '0;
        peak_neg_ms = '0;
        for (int i = 0; i < NUM_EVENTS; i++) begin
            pos_ring[i] = '0;
            neg_ring[i] = '0;
        end
        pos_slot    = 0;
        neg_slot    = 0;
        pos_latched = 1'b0;
        neg_latched = 1'b0;
        out_rate    = '0;
        mod_rate    = '0;
        gen_now     = 32'd5000;
        gen_sample  = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings, zero threshold: extremes of every field, a zero time
        // step, and timestamps that wrap around.
        push_request(32'h7FFF_FFFF, 20'd1, 32'd0);
        push_request(32'h8000_0000, 20'd1, 32'd1);
        push_request(32'h0000_0000, 20'd0, 32'hFFFF_FFFF);
        push_request(32'h0001_0000, 20'd1000000, 32'hFFFF_FFF0);
        push_request(32'hFFFF_0000, 20'd1000000, 32'h0000_0200);
        push_request(32'h0000_0000, 20'd2500, 32'h0000_0800);
        push_request(32'h0000_0000, 20'd0, 32'h0000_0800);
        for (int i = 0; i < 60; i++) push_random();
        phase_count++;
        wait_idle();

        // Small threshold, short time constant: exceedances in both directions,
        // then a long quiet stretch so the oldest exceedance gets attenuated.
        write_register(CFG_SLEW_MAX, 32'd65536 * 4);
        write_register(CFG_TAU, 32'd200000);
        push_request(32'h0010_0000, 20'd1000, 32'd10000);
        push_request(32'hFFF0_0000, 20'd1000, 32'd10001);
        push_request(32'h0010_0000, 20'd1000, 32'd10002);
        push_request(32'h0010_0000, 20'd10000, 32'd10012);
        push_request(32'h0010_0100, 20'd10000, 32'd10400);
        push_request(32'h0010_0200, 20'd10000, 32'd10950);
        push_request(32'h0010_0300, 20'd50000, 32'd12000);
        push_request(32'h0010_0400, 20'd50000, 32'd60000);
        push_request(32'h0010_0400, 20'd0, 32'd60000);
        push_request(32'h7FFF_FFFF, 20'd1, 32'd60001);
        push_request(32'h8000_0000, 20'd1, 32'd60002);
        push_request(32'h8000_0000, 20'd999999, 32'd61000);
        gen_now    = 32'd61000;
        gen_sample = 32'h8000_0000;
        phase_count++;
        wait_idle();

        // Register extremes, a zero time constant, a zero threshold after
        // exceedances, and two random settings.
        phase_max = '{32'd65536 * 20, 32'h7FFF_FFFF, 32'd1, 32'd300000, 32'd0,
                      32'd65536 * 2, $urandom_range(1, 32'h00FF_FFFF), $urandom};
        phase_tau = '{32'd1000, 32'd10000000, 32'd1, 32'd0, 32'd50000,
                      32'd1000000, $urandom_range(1, 10000000), $urandom_range(1, 10000)};
        for (int p = 0; p < 8; p++) begin
            write_register(CFG_SLEW_MAX, phase_max[p]);
            write_register(CFG_TAU, phase_tau[p]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++) push_random();
            phase_count++;
            // Every phase holds the sender until all results are back.
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d with a zero time step) over %0d register settings.",
                 accepted_count, zero_step_count, phase_count);
        $display("Checked %0d results, %0d mismatches.", result_count, error_count);
        if (error_count == 0 && expected_gains.size() == 0) begin
            $display("slew_rate_gain_modifier verification clean");
        end else begin
            if (expected_gains.size() != 0)
                report("results never delivered", expected_gains.size(), 0);
            $display("slew_rate_gain_modifier verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/srgm_pkg.sv
rtl/srgm_if.sv
rtl/srgm_div.sv
rtl/slew_rate_gain_modifier.sv
dv/slew_rate_gain_modifier_tb.sv
